// ===== src/extended_float_ones_complement_convert_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef EXTENDED_FLOAT_ONES_COMPLEMENT_CONVERT_UNIT_MACROS_SVH
`define EXTENDED_FLOAT_ONES_COMPLEMENT_CONVERT_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define EFOC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define EFOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/efoc_pkg.sv =====
// ---------------------------------------------------------------------------
// efoc_pkg
// Types and constants for the extended / ones'-complement real converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package efoc_pkg;

	localparam int RealW    = 54;
	localparam int SigW     = 64;
	localparam int ExpW     = 15;
	localparam int FracBits = 40;
	localparam int LzW      = 7;
	localparam int EW       = 18;

	localparam logic CMD_TO_PACKED   = 1'b0;
	localparam logic CMD_TO_EXTENDED = 1'b1;

	localparam logic [ExpW-1:0] EXT_EXP_ALL = 15'h7fff;

	typedef struct packed {
		logic            command;
		logic            ext_sign;
		logic [ExpW-1:0] ext_exponent;
		logic [SigW-1:0] ext_significand;
		logic [RealW-1:0] packed_real_in;
	} in_item_t;

	typedef struct packed {
		logic [RealW-1:0] packed_real_out;
		logic             ext_sign_out;
		logic [ExpW-1:0]  ext_exponent_out;
		logic [SigW-1:0]  ext_significand_out;
		logic             overflow;
	} out_item_t;

	// Leading-zero count of a 64-bit word, 64 for zero.
	function automatic logic [LzW-1:0] lzc64(input logic [SigW-1:0] v);
		logic [LzW-1:0] n;
		logic           found;
		n = LzW'(SigW);
		found = 1'b0;
		for (int i = SigW - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = LzW'(SigW - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ===== src/efoc_to_packed.sv =====
// ---------------------------------------------------------------------------
// efoc_to_packed
// Extended to ones'-complement real: normalise, round, pack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module efoc_to_packed (
	input  logic                           sign,
	input  logic [efoc_pkg::ExpW-1:0]      exponent,
	input  logic [efoc_pkg::SigW-1:0]      significand,
	output logic [efoc_pkg::RealW-1:0]     word,
	output logic                           overflow
);

	logic [efoc_pkg::LzW-1:0]   lz;
	logic [efoc_pkg::SigW-1:0]  n;
	logic [efoc_pkg::FracBits:0] r;
	logic [efoc_pkg::FracBits-1:0] frac;
	logic signed [efoc_pkg::EW-1:0] e;
	logic signed [efoc_pkg::EW-1:0] e_fin;
	logic [efoc_pkg::RealW-1:0] zero;
	logic [efoc_pkg::RealW-1:0] mag;

	always_comb begin
		lz = efoc_pkg::lzc64(significand);
		n = significand << lz;
		e = $signed({3'b000, ((exponent == '0) ? 15'd1 : exponent)})
			- 18'sd16382 - $signed({11'd0, lz});
		r = {1'b0, n[63:24]} + {40'd0, n[23]};
		// A carry out of the rounding add leaves a power of two.
		if (r[efoc_pkg::FracBits]) begin
			frac = r[efoc_pkg::FracBits:1];
			e_fin = e + 18'sd1;
		end else begin
			frac = r[efoc_pkg::FracBits-1:0];
			e_fin = e;
		end
		zero = sign ? '1 : '0;
		mag = {1'b0, frac[39:14], 1'b0, frac[13:0], 12'(e_fin + 18'sd2048)};
		overflow = 1'b0;
		word = '0;
		if (exponent == efoc_pkg::EXT_EXP_ALL) begin
			overflow = 1'b1;
		end else if (significand == '0) begin
			word = zero;
		end else if (e_fin > 18'sd2047) begin
			overflow = 1'b1;
		end else if (e_fin < -18'sd2048) begin
			word = zero;
		end else begin
			word = sign ? ~mag : mag;
		end
	end

endmodule

// ===== src/efoc_to_extended.sv =====
// ---------------------------------------------------------------------------
// efoc_to_extended
// Ones'-complement real to extended: unpack and normalise.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module efoc_to_extended (
	input  logic [efoc_pkg::RealW-1:0] word,
	output logic                       sign,
	output logic [efoc_pkg::ExpW-1:0]  exponent,
	output logic [efoc_pkg::SigW-1:0]  significand
);

	logic [efoc_pkg::RealW-1:0] p;
	logic [efoc_pkg::SigW-1:0]  m;
	logic [efoc_pkg::LzW-1:0]   lz;
	logic signed [efoc_pkg::EW-1:0] ex;

	always_comb begin
		sign = word[53];
		p = word[53] ? ~word : word;
		// The fraction sits one place below the top, so a normal value counts one leading zero.
		m = {1'b0, p[52:27], p[25:12], 23'd0};
		lz = efoc_pkg::lzc64(m);
		ex = $signed({6'd0, p[11:0]}) - 18'sd2048 - $signed({11'd0, lz}) + 18'sd16383;
		if (m == '0) begin
			exponent = '0;
			significand = '0;
		end else begin
			exponent = ex[efoc_pkg::ExpW-1:0];
			significand = m << lz;
		end
	end

endmodule

// ===== src/extended_float_ones_complement_convert_unit.sv =====
// ---------------------------------------------------------------------------
// extended_float_ones_complement_convert_unit
// Two-way converter between 80-bit extended and 54-bit ones'-complement reals.
// ---------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready as one in_item_t; the command bit
// picks the direction. Results leave on out_valid/out_ready as out_item_t,
// with the fields of the unused direction held at zero.
// The item is captured in an input register, converted by the combinational
// datapath (leading-zero count, rounding add and packing) and caught in the
// result register. Throughput is one item per cycle while the receiver
// takes them. If the receiver stalls, the result register holds its item
// and the input register fills; ready then falls until the output drains.
// Reset clears both valid flags; the block is ready from the first cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended_float_ones_complement_convert_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  efoc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output efoc_pkg::out_item_t  out_data
);

	efoc_pkg::in_item_t  item_s1;
	logic                valid_s1;
	efoc_pkg::out_item_t res_s2;
	logic                valid_s2;
	efoc_pkg::out_item_t res;
	logic [efoc_pkg::RealW-1:0] pk_word;
	logic                pk_ovf;
	logic                ex_sign;
	logic [efoc_pkg::ExpW-1:0] ex_exp;
	logic [efoc_pkg::SigW-1:0] ex_sig;
	logic                adv_s2;

	efoc_to_packed u_pk (
		.sign        (item_s1.ext_sign),
		.exponent    (item_s1.ext_exponent),
		.significand (item_s1.ext_significand),
		.word        (pk_word),
		.overflow    (pk_ovf)
	);

	efoc_to_extended u_ex (
		.word        (item_s1.packed_real_in),
		.sign        (ex_sign),
		.exponent    (ex_exp),
		.significand (ex_sig)
	);

	always_comb begin
		res = '0;
		if (item_s1.command == efoc_pkg::CMD_TO_EXTENDED) begin
			res.ext_sign_out = ex_sign;
			res.ext_exponent_out = ex_exp;
			res.ext_significand_out = ex_sig;
		end else begin
			res.packed_real_out = pk_word;
			res.overflow = pk_ovf;
		end
	end

	assign adv_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign out_valid = valid_s2;
	assign out_data = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
		if (adv_s2 && valid_s1) res_s2 <= res;
	end

endmodule

// ===== src/efoc_checker.sv =====
// ---------------------------------------------------------------------------
// efoc_checker
// Port-level checks on the converter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "extended_float_ones_complement_convert_unit_macros.svh"

module efoc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input efoc_pkg::out_item_t out_data
);

	`EFOC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
	`EFOC_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready, "not ready with empty output")
	`EFOC_ASSERT_NEXT(a_in_to_out, clk, arst_n, in_valid && in_ready && out_ready, ##1 out_valid, "item lost")
	`EFOC_ASSERT_IMP(a_ovf_dir, clk, arst_n, out_valid && out_data.overflow, out_data.ext_exponent_out == '0 && out_data.packed_real_out == '0, "overflow with data")

endmodule

bind extended_float_ones_complement_convert_unit efoc_checker u_efoc_checker (.*);

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Converter testbench
// Drives extended and packed reals through the converter under random idling
// on both sides, predicts every result in the testbench and compares each
// result field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class conv_scoreboard;
	efoc_pkg::out_item_t pending[$];
	int errors;
	int checked;

	function automatic efoc_pkg::out_item_t convert(efoc_pkg::in_item_t it);
		efoc_pkg::out_item_t o;
		logic [63:0] n;
		logic [63:0] m;
		logic [53:0] p;
		logic [53:0] w;
		logic [40:0] r;
		int lz;
		int e;
		o = '0;
		if (it.command == efoc_pkg::CMD_TO_EXTENDED) begin
			p = it.packed_real_in;
			o.ext_sign_out = p[53];
			if (p[53])
				p = ~p;
			m = {1'b0, p[52:27], 37'h0} | ({50'h0, p[25:12]} << 23);
			if (m != 0) begin
				lz = 0;
				while (!m[63]) begin
					m = m << 1;
					lz++;
				end
				e = int'(p[11:0]) - 2048 - lz + 16383;
				o.ext_exponent_out = e[14:0];
				o.ext_significand_out = m;
			end
		end else if (it.ext_exponent == efoc_pkg::EXT_EXP_ALL) begin
			o.overflow = 1'b1;
		end else if (it.ext_significand == 0) begin
			o.packed_real_out = it.ext_sign ? {54{1'b1}} : '0;
		end else begin
			n = it.ext_significand;
			lz = 0;
			while (!n[63]) begin
				n = n << 1;
				lz++;
			end
			e = (it.ext_exponent != 0 ? int'(it.ext_exponent) : 1) - 16382 - lz;
			r = {1'b0, n[63:24]};
			if (n[23]) begin
				r = r + 1;
				if (r[40]) begin
					r = r >> 1;
					e++;
				end
			end
			if (e > 2047)
				o.overflow = 1'b1;
			else if (e < -2048)
				o.packed_real_out = it.ext_sign ? {54{1'b1}} : '0;
			else begin
				w = {1'b0, r[39:14], 1'b0, r[13:0], 12'h0};
				w[11:0] = 12'(e + 2048);
				o.packed_real_out = it.ext_sign ? ~w : w;
			end
		end
		return o;
	endfunction

	function void note_input(efoc_pkg::in_item_t it);
		pending.push_back(convert(it));
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		errors++;
	endtask

	task check_result(efoc_pkg::out_item_t got);
		efoc_pkg::out_item_t want;
		checked++;
		if (pending.size() == 0) begin
			report("unexpected result", 64'(got.packed_real_out), 0);
			return;
		end
		want = pending.pop_front();
		if (got.packed_real_out !== want.packed_real_out)
			report("packed_real_out", 64'(got.packed_real_out), 64'(want.packed_real_out));
		if (got.ext_sign_out !== want.ext_sign_out)
			report("ext_sign_out", 64'(got.ext_sign_out), 64'(want.ext_sign_out));
		if (got.ext_exponent_out !== want.ext_exponent_out)
			report("ext_exponent_out", 64'(got.ext_exponent_out), 64'(want.ext_exponent_out));
		if (got.ext_significand_out !== want.ext_significand_out)
			report("ext_significand_out", got.ext_significand_out, want.ext_significand_out);
		if (got.overflow !== want.overflow)
			report("overflow", 64'(got.overflow), 64'(want.overflow));
	endtask
endclass

module testbench;

	localparam int NumRandom = 1300;
	localparam int IdleLimit = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	efoc_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	efoc_pkg::out_item_t out_data;

	conv_scoreboard board;
	int sent;
	int idle_cycles;
	int stall_left;
	bit quiet;
	bit hold_off;

	extended_float_ones_complement_convert_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task send_item(efoc_pkg::in_item_t it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_input(it);
		sent++;
		@(negedge clk);
	endtask

	task send_to_packed(logic s, logic [14:0] x, logic [63:0] g);
		efoc_pkg::in_item_t it;
		it = '0;
		it.command = efoc_pkg::CMD_TO_PACKED;
		it.ext_sign = s;
		it.ext_exponent = x;
		it.ext_significand = g;
		it.packed_real_in = 54'({$urandom, $urandom});
		send_item(it);
	endtask

	task send_to_extended(logic [53:0] p);
		efoc_pkg::in_item_t it;
		it = '0;
		it.command = efoc_pkg::CMD_TO_EXTENDED;
		it.ext_sign = 1'($urandom);
		it.ext_exponent = 15'($urandom);
		it.ext_significand = {$urandom, $urandom};
		it.packed_real_in = p;
		send_item(it);
	endtask

	// Output side: random stall bursts, one long hold-off, and none when quiet.
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			out_ready <= 1'b0;
		else if (quiet)
			out_ready <= 1'b1;
		else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= int'($urandom_range(0, 14));
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		hold_off = 1'b0;
		repeat (150) @(negedge clk);
		hold_off = 1'b1;
		repeat (200) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		logic [63:0] g;
		int x;
		board = new();
		sent = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: zeros, infinity, extremes, rounding carry, denormals, unnormals.
		send_to_packed(0, 15'h3fff, 64'h0);
		send_to_packed(1, 15'h1234, 64'h0);
		send_to_packed(0, 15'h7fff, 64'h8000_0000_0000_0000);
		send_to_packed(1, 15'h7fff, 64'hc000_0000_0000_0001);
		send_to_packed(0, 15'h3fff, 64'hffff_ffff_ffff_ffff);
		send_to_packed(1, 15'h3fff, 64'hffff_ff80_0000_0000);
		send_to_packed(0, 15'h3fff, 64'h8000_0000_0080_0000);
		send_to_packed(0, 15'h0, 64'h0000_0000_0000_0001);
		send_to_packed(1, 15'h0, 64'h7fff_ffff_ffff_ffff);
		send_to_packed(0, 15'h4100, 64'h0000_0123_4567_89ab);
		send_to_packed(0, 15'h7ffe, 64'hffff_ffff_ffff_ffff);
		send_to_packed(1, 15'd18430, 64'hffff_ffff_ffff_ffff);
		send_to_packed(0, 15'd18429, 64'hffff_ff7f_ffff_ffff);
		send_to_packed(1, 15'd14335, 64'h8000_0000_0000_0000);
		send_to_packed(0, 15'd14334, 64'hffff_ffff_ffff_ffff);
		send_to_packed(0, 15'd14334, 64'h8000_0000_0000_0000);
		send_to_extended(54'h0);
		send_to_extended({54{1'b1}});
		send_to_extended(54'h000_0000_0400_0fff);
		send_to_extended(54'h1f_ffff_f7ff_ffff);
		send_to_extended(54'h000_0000_0000_1000);
		send_to_extended(54'h20_0000_0000_0abc);
		send_to_extended(54'h3f_ffff_ffff_f000);

		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom - 200)
				quiet = 1'b1;
			g = {$urandom, $urandom};
			if ($urandom_range(0, 3) == 0)
				g = g >> $urandom_range(0, 63);
			case ($urandom_range(0, 4))
				0: x = $urandom_range(0, 32767);
				1: x = $urandom_range(0, 3) == 0 ? 0 : 32767;
				2: x = 16383 + $urandom_range(0, 4200) - 2100;
				default: x = 16383 + $urandom_range(0, 100) - 50;
			endcase
			if ($urandom_range(0, 1))
				send_to_packed(1'($urandom), 15'(x), g);
			else
				send_to_extended(54'(g));
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("ran %0d items in both directions, %0d results checked", sent,
			board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
